@@ design/owtr_pkg.sv @@
`default_nettype none
package owtr_pkg;
  localparam int TIMER_WIDTH_DEF = 20;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 20;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] CFG_RESET_LOW = 3'd0;
  localparam logic [2:0] CFG_RESET_REL = 3'd1;
  localparam logic [2:0] CFG_PRES_WAIT = 3'd2;
  localparam logic [2:0] CFG_PRES_END = 3'd3;
  localparam logic [2:0] CFG_CONV_WAIT = 3'd4;
  localparam logic [2:0] CFG_SLOT_TIME = 3'd5;
  localparam logic [2:0] CFG_SAMPLE_OFF = 3'd6;
  localparam logic [2:0] CFG_READ_REC = 3'd7;

  localparam logic [7:0] CMD_SKIP = 8'hCC;
  localparam logic [7:0] CMD_CONVERT = 8'h44;
  localparam logic [7:0] CMD_READ = 8'hBE;
  localparam logic [1:0] EDGE_US = 2'd2;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NO_PRES = 2'd1;
  localparam logic [1:0] ST_PRES_STUCK = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE, S_R1_LOW, S_R1_REL, S_R1_WAIT, S_R1_END, S_W_SKIP1, S_W_CONV, S_CWAIT,
    S_R2_LOW, S_R2_REL, S_R2_WAIT, S_R2_END, S_W_SKIP2, S_W_RDCMD, S_RD_LO, S_RD_HI
  } step_t;

  typedef enum logic [1:0] {OP_TICK, OP_START} op_t;

  typedef struct packed {
    op_t  op;
    logic line;
  } work_t;

  typedef struct packed {
    logic [15:0] temperature;
    logic [1:0]  status;
    logic        done_res;
    logic        busy_res;
    logic        drive_low;
  } result_t;

  typedef struct packed {
    logic [9:0]  reset_low_us;
    logic [7:0]  reset_release_us;
    logic [7:0]  presence_wait_limit;
    logic [7:0]  presence_end_limit;
    logic [19:0] conversion_wait_us;
    logic [7:0]  slot_time_us;
    logic [5:0]  sample_offset_us;
    logic [7:0]  read_recovery_us;
  } cfg_t;
endpackage
`default_nettype wire

@@ design/owtr_front.sv @@
`default_nettype none
module owtr_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [1:0]      in_data,
  output owtr_pkg::work_t      q_data,
  output logic                 q_valid,
  input  wire logic            q_ready
);
  import owtr_pkg::*;

  work_t            mem_r [QUEUE_DEPTH];
  logic             wp_r, rp_r;
  logic [1:0]       cnt_r;
  logic             push, pop;
  work_t            w;

  always_comb begin
    w.op = in_data[0] ? OP_START : OP_TICK;
    w.line = in_data[1];
  end

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = mem_r[rp_r];
  assign push = in_valid && in_ready;
  assign pop  = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= w;
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule
`default_nettype wire

@@ design/owtr_back.sv @@
`default_nettype none
module owtr_back #(
  parameter int TIMER_WIDTH = owtr_pkg::TIMER_WIDTH_DEF
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire owtr_pkg::cfg_t  cfg,
  input  wire owtr_pkg::work_t q_data,
  input  wire logic            q_valid,
  output logic                 q_ready,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output owtr_pkg::result_t    out_res
);
  import owtr_pkg::*;

  step_t                  step_r, step_nxt;
  logic [2:0]             phase_r, phase_nxt;
  logic [TIMER_WIDTH-1:0] tc_r, tc_nxt;
  logic [7:0]             retry_r, retry_nxt;
  logic [2:0]             bit_r, bit_nxt;
  logic [7:0]             sh_r, sh_nxt;
  logic [7:0]             lo_r, lo_nxt;
  logic [7:0]             hi_r, hi_nxt;
  logic                   ov_r;
  result_t                res_r;
  result_t                res;
  logic                   fire;

  logic [TIMER_WIDTH-1:0] dur, dmask, tinc;
  logic                   el;
  logic [7:0]             rinc;
  logic                   done;
  logic [1:0]             st;
  logic                   last_bit;

  assign q_ready = !ov_r || out_ready;
  assign fire = q_valid && q_ready;
  assign out_valid = ov_r;
  assign out_res = res_r;

  always_comb begin
    dur = '0;
    case (step_r)
      S_R1_LOW, S_R2_LOW: dur = TIMER_WIDTH'(cfg.reset_low_us);
      S_R1_REL, S_R2_REL: dur = TIMER_WIDTH'(cfg.reset_release_us);
      S_CWAIT: dur = TIMER_WIDTH'(cfg.conversion_wait_us);
      S_W_SKIP1, S_W_CONV, S_W_SKIP2, S_W_RDCMD:
        dur = (phase_r == 3'd1) ? TIMER_WIDTH'(cfg.slot_time_us) : TIMER_WIDTH'(EDGE_US);
      S_RD_LO, S_RD_HI:
        case (phase_r)
          3'd0: dur = TIMER_WIDTH'(EDGE_US);
          3'd1: dur = TIMER_WIDTH'(cfg.sample_offset_us);
          default: dur = TIMER_WIDTH'(cfg.read_recovery_us);
        endcase
      default: dur = '0;
    endcase
    dmask = (dur == '0) ? TIMER_WIDTH'(1) : dur;
    tinc = tc_r + TIMER_WIDTH'(1);
    el = (tinc >= dmask);
  end

  always_comb begin
    step_nxt = step_r;
    phase_nxt = phase_r;
    tc_nxt = tc_r;
    retry_nxt = retry_r;
    bit_nxt = bit_r;
    sh_nxt = sh_r;
    lo_nxt = lo_r;
    hi_nxt = hi_r;
    done = 1'b0;
    st = ST_OK;
    rinc = retry_r + 8'd1;
    last_bit = (bit_r == 3'd7);
    if (q_data.op == OP_START) begin
      if (step_r == S_IDLE) begin
        step_nxt = S_R1_LOW;
        phase_nxt = '0; tc_nxt = '0; retry_nxt = '0; bit_nxt = '0;
        sh_nxt = '0; lo_nxt = '0; hi_nxt = '0;
      end
    end else begin
      case (step_r)
        S_R1_LOW, S_R2_LOW, S_R1_REL, S_R2_REL, S_CWAIT: begin
          tc_nxt = el ? '0 : tinc;
          if (el) begin
            step_nxt = (step_r == S_CWAIT) ? S_R2_LOW : step_t'(step_r + 4'd1);
            retry_nxt = (step_r == S_R1_REL || step_r == S_R2_REL) ? 8'd0 : retry_r;
          end
        end
        S_R1_WAIT, S_R2_WAIT: begin
          if (!q_data.line) begin
            step_nxt = step_t'(step_r + 4'd1);
            retry_nxt = '0;
          end else begin
            retry_nxt = rinc;
            if (rinc >= cfg.presence_wait_limit) begin
              done = 1'b1; st = ST_NO_PRES;
            end
          end
        end
        S_R1_END, S_R2_END: begin
          if (q_data.line) begin
            step_nxt = (step_r == S_R1_END) ? S_W_SKIP1 : S_W_SKIP2;
            sh_nxt = CMD_SKIP; bit_nxt = '0; phase_nxt = '0; tc_nxt = '0;
          end else begin
            retry_nxt = rinc;
            if (rinc >= cfg.presence_end_limit) begin
              done = 1'b1; st = ST_PRES_STUCK;
            end
          end
        end
        S_W_SKIP1, S_W_CONV, S_W_SKIP2, S_W_RDCMD: begin
          tc_nxt = el ? '0 : tinc;
          if (el) begin
            if (phase_r == 3'd0) phase_nxt = 3'd1;
            else if (phase_r == 3'd1 && !sh_r[0]) phase_nxt = 3'd2;
            else begin
              sh_nxt = sh_r >> 1;
              phase_nxt = '0;
              bit_nxt = last_bit ? 3'd0 : bit_r + 3'd1;
              if (last_bit) begin
                case (step_r)
                  S_W_SKIP1: begin step_nxt = S_W_CONV; sh_nxt = CMD_CONVERT; end
                  S_W_CONV: step_nxt = S_CWAIT;
                  S_W_SKIP2: begin step_nxt = S_W_RDCMD; sh_nxt = CMD_READ; end
                  default: begin step_nxt = S_RD_LO; sh_nxt = '0; end
                endcase
              end
            end
          end
        end
        S_RD_LO, S_RD_HI: begin
          tc_nxt = el ? '0 : tinc;
          if (el) begin
            if (phase_r == 3'd0) phase_nxt = 3'd1;
            else if (phase_r == 3'd1) begin
              sh_nxt = {q_data.line, sh_r[7:1]};
              phase_nxt = 3'd2;
            end else begin
              phase_nxt = '0;
              bit_nxt = last_bit ? 3'd0 : bit_r + 3'd1;
              if (last_bit) begin
                if (step_r == S_RD_LO) begin
                  lo_nxt = sh_r; step_nxt = S_RD_HI; sh_nxt = '0;
                end else begin
                  hi_nxt = sh_r; done = 1'b1; st = ST_OK;
                end
              end
            end
          end
        end
        default: ;
      endcase
    end
    if (done) begin
      step_nxt = S_IDLE;
      phase_nxt = '0; tc_nxt = '0; retry_nxt = '0; bit_nxt = '0;
    end
    res.done_res = done;
    res.status = done ? st : ST_OK;
    res.temperature = (done && st == ST_OK) ? {hi_nxt, lo_nxt} : 16'd0;
    res.busy_res = (step_nxt != S_IDLE);
    case (step_nxt)
      S_R1_LOW, S_R2_LOW: res.drive_low = 1'b1;
      S_W_SKIP1, S_W_CONV, S_W_SKIP2, S_W_RDCMD:
        res.drive_low = (phase_nxt == 3'd0) || (phase_nxt == 3'd1 && !sh_nxt[0]);
      S_RD_LO, S_RD_HI: res.drive_low = (phase_nxt == 3'd0);
      default: res.drive_low = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
      ov_r <= 1'b0;
      phase_r <= '0;
      tc_r <= '0;
      retry_r <= '0;
      bit_r <= '0;
      sh_r <= '0;
      lo_r <= '0;
      hi_r <= '0;
    end else begin
      if (fire) begin
        res_r <= res;
        step_r <= step_nxt;
        sh_r <= sh_nxt;
        lo_r <= lo_nxt;
        hi_r <= hi_nxt;
        tc_r <= tc_nxt;
        retry_r <= retry_nxt;
        bit_r <= bit_nxt;
        phase_r <= phase_nxt;
      end
      if (fire) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end
endmodule
`default_nettype wire

@@ design/onewire_temperature_reader.sv @@
// Path: a word waits in the two-entry queue; its result is registered at the edge that takes
//   its tick from the queue, into the output register.
// Throughput: one word per cycle unless the output stalls; one sequencer step per word.
// Reset: synchronous active-low rst_n clears the queue, the sequencer (idle) and the output
//   valid, but not the result data, and loads the timing registers with their defaults.
`default_nettype none
module onewire_temperature_reader #(
  parameter int TIMER_WIDTH = owtr_pkg::TIMER_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // command, line_level
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [23:0]      out_tdata,  // drive_low, busy_res, done_res, status[2], temperature[16]
  input  wire logic        cfg_we,
  input  wire logic [owtr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [owtr_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import owtr_pkg::*;

  cfg_t    cfg_r;
  work_t   q_data;
  logic    q_valid, q_ready;
  result_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_us <= 10'd720;
      cfg_r.reset_release_us <= 8'd60;
      cfg_r.presence_wait_limit <= 8'd200;
      cfg_r.presence_end_limit <= 8'd240;
      cfg_r.conversion_wait_us <= 20'd750000;
      cfg_r.slot_time_us <= 8'd60;
      cfg_r.sample_offset_us <= 6'd10;
      cfg_r.read_recovery_us <= 8'd50;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RESET_LOW: cfg_r.reset_low_us <= cfg_wdata[9:0];
        CFG_RESET_REL: cfg_r.reset_release_us <= cfg_wdata[7:0];
        CFG_PRES_WAIT: cfg_r.presence_wait_limit <= cfg_wdata[7:0];
        CFG_PRES_END: cfg_r.presence_end_limit <= cfg_wdata[7:0];
        CFG_CONV_WAIT: cfg_r.conversion_wait_us <= cfg_wdata[19:0];
        CFG_SLOT_TIME: cfg_r.slot_time_us <= cfg_wdata[7:0];
        CFG_SAMPLE_OFF: cfg_r.sample_offset_us <= cfg_wdata[5:0];
        CFG_READ_REC: cfg_r.read_recovery_us <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  owtr_front u_front (
    .clk, .rst_n,
    .in_valid(in_tvalid), .in_ready(in_tready), .in_data(in_tdata[1:0]),
    .q_data, .q_valid, .q_ready
  );

  owtr_back #(.TIMER_WIDTH(TIMER_WIDTH)) u_back (
    .clk, .rst_n, .cfg(cfg_r),
    .q_data, .q_valid, .q_ready,
    .out_valid(out_tvalid), .out_ready(out_tready), .out_res(res)
  );

  assign out_tdata = {3'b000, res};

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> !out_tdata[1]) else $error("done while busy");
  a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[2] |-> out_tdata[4:3] == 2'd0) else $error("status without done");
  a_err_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[4:3] != 2'd0 |-> !out_tdata[0] && out_tdata[20:5] == 16'd0)
    else $error("error end not clean");
endmodule
`default_nettype wire
